// File: sv/cdz_pkg.sv
// shared types and constants for the camera dead-zone scroll tracker
// no dependencies; used by every module of the block

package cdz_pkg;

    localparam int POS_W    = 12;
    localparam int CAM_W    = 13;
    localparam int STEP_W   = 5;
    localparam int DIR_W    = 6;
    localparam int REM_W    = 4;
    localparam int MARGIN_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_RIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_TOP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_BOTTOM = 3'd5;

    // request kinds carried in tuser
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    // reset values of the dead zone margins
    localparam logic [MARGIN_W-1:0] MARGIN_LEFT_RST   = MARGIN_W'(16 * 3);
    localparam logic [MARGIN_W-1:0] MARGIN_RIGHT_RST  = MARGIN_W'(16 * 11);
    localparam logic [MARGIN_W-1:0] MARGIN_TOP_RST    = MARGIN_W'(16 * 2);
    localparam logic [MARGIN_W-1:0] MARGIN_BOTTOM_RST = MARGIN_W'(16 * 7);

    typedef struct packed {
        logic [POS_W-1:0]    limit_x;
        logic [POS_W-1:0]    limit_y;
        logic [MARGIN_W-1:0] margin_left;
        logic [MARGIN_W-1:0] margin_right;
        logic [MARGIN_W-1:0] margin_top;
        logic [MARGIN_W-1:0] margin_bottom;
    } t_cfg;

    // per-axis tracking state
    typedef struct packed {
        logic [CAM_W-1:0] cam;
        logic [REM_W-1:0] rem;
        logic [DIR_W-1:0] dir;
    } t_axis_state;

endpackage

// File: sv/cdz_cfg.sv
// configuration register file: limits and dead zone margins
// depends on cdz_pkg

module cdz_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cdz_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cdz_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output cdz_pkg::t_cfg                 o_cfg
);

    cdz_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limit_x       <= '0;
            r_cfg.limit_y       <= '0;
            r_cfg.margin_left   <= cdz_pkg::MARGIN_LEFT_RST;
            r_cfg.margin_right  <= cdz_pkg::MARGIN_RIGHT_RST;
            r_cfg.margin_top    <= cdz_pkg::MARGIN_TOP_RST;
            r_cfg.margin_bottom <= cdz_pkg::MARGIN_BOTTOM_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cdz_pkg::CFG_LIMIT_X:       r_cfg.limit_x <= i_cfg_data;
                cdz_pkg::CFG_LIMIT_Y:       r_cfg.limit_y <= i_cfg_data;
                cdz_pkg::CFG_MARGIN_LEFT:
                    r_cfg.margin_left <= i_cfg_data[cdz_pkg::MARGIN_W-1:0];
                cdz_pkg::CFG_MARGIN_RIGHT:
                    r_cfg.margin_right <= i_cfg_data[cdz_pkg::MARGIN_W-1:0];
                cdz_pkg::CFG_MARGIN_TOP:
                    r_cfg.margin_top <= i_cfg_data[cdz_pkg::MARGIN_W-1:0];
                cdz_pkg::CFG_MARGIN_BOTTOM:
                    r_cfg.margin_bottom <= i_cfg_data[cdz_pkg::MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// File: sv/cdz_axis.sv
// one axis of dead zone scrolling followed by the sub-tile glide
// combinational; depends on cdz_pkg

module cdz_axis (
    input  cdz_pkg::t_axis_state           i_state,
    input  logic [cdz_pkg::POS_W-1:0]      i_pos,
    input  logic [cdz_pkg::STEP_W-1:0]     i_step,
    input  logic [cdz_pkg::MARGIN_W-1:0]   i_margin_low,
    input  logic [cdz_pkg::MARGIN_W-1:0]   i_margin_high,
    input  logic [cdz_pkg::POS_W-1:0]      i_limit,
    input  logic                           i_glide_en,
    output cdz_pkg::t_axis_state           o_state,
    output logic                           o_moved
);

    logic signed [14:0] c0;
    logic signed [14:0] c1;
    logic signed [14:0] pos_s;
    logic signed [14:0] mlow_s;
    logic signed [14:0] mhigh_s;
    logic signed [14:0] step_s;
    logic [12:0]        c1_dec;
    logic [12:0]        c2_inc;
    logic [12:0]        cam2;
    logic [13:0]        hi_bound;
    logic               low_hit;
    logic               low_under;
    logic               high_hit;
    logic               high_over;
    logic               moved;
    cdz_pkg::t_axis_state s;

    assign pos_s   = $signed({3'b0, i_pos});
    assign mlow_s  = $signed({7'b0, i_margin_low});
    assign mhigh_s = $signed({7'b0, i_margin_high});
    assign step_s  = $signed({10'b0, i_step});
    assign c0      = $signed({{2{i_state.cam[12]}}, i_state.cam});

    assign low_hit   = (c0 + mlow_s) > pos_s;
    assign low_under = i_pos < {4'b0, i_margin_low};
    assign c1_dec    = 13'(c0 - step_s);
    // snap to zero if the cursor sits inside the low margin of the map
    assign c1 = !low_hit   ? c0 :
                low_under ? '0 : $signed({{2{c1_dec[12]}}, c1_dec});

    assign high_hit  = (c1 + mhigh_s) < pos_s;
    assign hi_bound  = {2'b0, i_limit} + {6'b0, i_margin_high};
    assign high_over = {2'b0, i_pos} > hi_bound;
    assign c2_inc    = 13'(c1 + step_s);
    assign cam2 = !high_hit ? c1[12:0] :
                  high_over ? {1'b0, i_limit} : c2_inc;

    assign moved = (low_hit && !low_under) || (high_hit && !high_over);

    always_comb begin
        s     = i_state;
        s.cam = cam2;
        if (low_hit && !low_under) begin
            s.dir = 6'(6'd0 - {1'b0, i_step});
            s.rem = c1_dec[3:0];
        end
        if (high_hit && !high_over) begin
            s.dir = {1'b0, i_step};
            s.rem = c2_inc[3:0];
        end
        // glide toward the next 16-pixel boundary by the last step
        if (i_glide_en && (s.rem != '0)) begin
            s.rem = s.rem + s.dir[3:0];
            s.cam = s.cam + {{7{s.dir[5]}}, s.dir};
        end
    end

    assign o_state = s;
    assign o_moved = moved;

endmodule

// File: sv/camera_deadzone_scroll_core.sv
// camera dead-zone scroll tracker, top level
// an input transaction passes through the input register, then the result register
// throughput: one transaction per cycle while the master side keeps tready high
// a held result lets the input register take one more transaction, then tready drops
// reset (synchronous, active low) clears camera state and valids, config back to defaults
// depends on cdz_pkg, cdz_cfg, cdz_axis

module camera_deadzone_scroll_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata: pos_x [11:0], pos_y [23:12], step [28:24], zero [31:29]
    input  logic [cdz_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // tuser: req_type [0]
    input  logic                             i_s_tuser,
    // master side
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata: view_x [12:0], view_y [25:13], scrolled [26], zero [31:27]
    output logic [cdz_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cdz_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cdz_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    cdz_pkg::t_cfg        cfg;
    cdz_pkg::t_axis_state r_sx, r_sy;
    cdz_pkg::t_axis_state n_sx, n_sy;
    cdz_pkg::t_axis_state ax_x, ax_y;

    logic                          r_in_vld;
    logic                          r_req;
    logic [cdz_pkg::POS_W-1:0]     r_pos_x;
    logic [cdz_pkg::POS_W-1:0]     r_pos_y;
    logic [cdz_pkg::STEP_W-1:0]    r_step;

    logic                          r_out_vld;
    logic [cdz_pkg::CAM_W-1:0]     r_view_x;
    logic [cdz_pkg::CAM_W-1:0]     r_view_y;
    logic                          r_scrolled;
    logic                          n_scrolled;

    logic moved_x, moved_y;
    logic adv;
    logic s_xfer;

    cdz_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cdz_axis u_axis_x (
        .i_state       (r_sx),
        .i_pos         (r_pos_x),
        .i_step        (r_step),
        .i_margin_low  (cfg.margin_left),
        .i_margin_high (cfg.margin_right),
        .i_limit       (cfg.limit_x),
        .i_glide_en    (!(moved_x || moved_y)),
        .o_state       (ax_x),
        .o_moved       (moved_x)
    );

    cdz_axis u_axis_y (
        .i_state       (r_sy),
        .i_pos         (r_pos_y),
        .i_step        (r_step),
        .i_margin_low  (cfg.margin_top),
        .i_margin_high (cfg.margin_bottom),
        .i_limit       (cfg.limit_y),
        .i_glide_en    (!(moved_x || moved_y)),
        .o_state       (ax_y),
        .o_moved       (moved_y)
    );

    // the input register moves on whenever the result register is free or drains
    assign adv        = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || adv;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    always_comb begin
        if (r_req == cdz_pkg::REQ_LOAD) begin
            n_sx       = r_sx;
            n_sy       = r_sy;
            n_sx.cam   = {1'b0, r_pos_x};
            n_sy.cam   = {1'b0, r_pos_y};
            n_sx.rem   = '0;
            n_sy.rem   = '0;
            n_scrolled = 1'b0;
        end else begin
            n_sx       = ax_x;
            n_sy       = ax_y;
            n_scrolled = moved_x || moved_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_sx      <= '0;
            r_sy      <= '0;
        end else begin
            if (s_xfer) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
                r_sx      <= n_sx;
                r_sy      <= n_sy;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_req   <= i_s_tuser;
            r_pos_x <= i_s_tdata[11:0];
            r_pos_y <= i_s_tdata[23:12];
            r_step  <= i_s_tdata[28:24];
        end
        if (adv) begin
            r_view_x   <= n_sx.cam;
            r_view_y   <= n_sy.cam;
            r_scrolled <= n_scrolled;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'b0, r_scrolled, r_view_y, r_view_x};

endmodule

// File: sv/cdz_checker.sv
// port-level checks for camera_deadzone_scroll_core, attached by bind
// depends on cdz_pkg

module cdz_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic [cdz_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input logic                             i_s_tuser,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [cdz_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready
);

    logic s_xfer;
    assign s_xfer = i_s_tvalid && o_s_tready;

    // a stalled result keeps its valid and its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // a load into an empty pipe passes through the input and result registers, echoed unclamped
    a_load_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer && (i_s_tuser == cdz_pkg::REQ_LOAD) && !o_m_tvalid && !$past(s_xfer)
        |=> ##1 o_m_tvalid
            && (o_m_tdata[12:0] == {1'b0, $past(i_s_tdata[11:0], 2)})
            && (o_m_tdata[25:13] == {1'b0, $past(i_s_tdata[23:12], 2)})
            && !o_m_tdata[26])
        else $error("load result mismatch");

    // the configuration channel never stalls
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write stalled");

endmodule

bind camera_deadzone_scroll_core cdz_checker u_cdz_checker (.*);

// File: tb/tb.sv
// testbench for camera_deadzone_scroll_core: directed table, then four random phases
// with sender gaps and receiver stalls; results checked against an in-bench tracker model
// depends on cdz_pkg and camera_deadzone_scroll_core
`timescale 1ns / 100ps

module tb;

    localparam int RANDOM_ITEMS = 1250;
    localparam int PIPE_SETTLE  = 4;
    localparam int QUIET_LIMIT  = 2000;

    typedef struct packed {
        logic [cdz_pkg::CAM_W-1:0] view_x;
        logic [cdz_pkg::CAM_W-1:0] view_y;
        logic                      scrolled;
    } t_view_result;

    typedef struct packed {
        cdz_pkg::t_axis_state st;
        logic                 moved;
    } t_axis_move;

    // one row of the directed table: either a register write or a request
    typedef struct packed {
        logic                           is_cfg;
        logic [cdz_pkg::CFG_IDX_W-1:0]  idx;
        logic [cdz_pkg::CFG_DATA_W-1:0] data;
        logic                           req;
        logic [cdz_pkg::POS_W-1:0]      px;
        logic [cdz_pkg::POS_W-1:0]      py;
        logic [cdz_pkg::STEP_W-1:0]     stp;
        logic                           typed;
        t_view_result                   want;
    } t_probe_row;

    logic                             i_clk;
    logic                             i_rst_n     = 1'b0;
    logic                             i_s_tvalid  = 1'b0;
    logic                             o_s_tready;
    logic [cdz_pkg::IN_DATA_W-1:0]    i_s_tdata   = '0;
    logic                             i_s_tuser   = 1'b0;
    logic                             o_m_tvalid;
    logic                             i_m_tready  = 1'b0;
    logic [cdz_pkg::OUT_DATA_W-1:0]   o_m_tdata;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [cdz_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [cdz_pkg::CFG_DATA_W-1:0]   i_cfg_data  = '0;

    // tracker model state and its copy of the registers
    cdz_pkg::t_axis_state track_x;
    cdz_pkg::t_axis_state track_y;
    cdz_pkg::t_cfg        view_cfg;

    t_view_result expected_views[$];
    t_probe_row   probe_rows[$];
    int           mismatch_count = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           quiet_cycles   = 0;
    logic         cfg_open       = 1'b0;

    camera_deadzone_scroll_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // margin checks on one axis: low side first, then high side on the updated camera
    function automatic t_axis_move scroll_axis(cdz_pkg::t_axis_state st, int pos, int stp,
                                               int mlow, int mhigh, int lim);
        t_axis_move                res;
        logic [cdz_pkg::CAM_W-1:0] w;
        int                        c;
        res.moved = 1'b0;
        c = $signed(st.cam);
        if (c + mlow > pos) begin
            if (pos - mlow < 0) begin
                c = 0;
            end else begin
                res.moved = 1'b1;
                w = cdz_pkg::CAM_W'(c - stp);
                c = $signed(w);
                st.dir = cdz_pkg::DIR_W'(-stp);
                st.rem = w[cdz_pkg::REM_W-1:0];
            end
        end
        if (c + mhigh < pos) begin
            if (pos - mhigh > lim) begin
                c = lim;
            end else begin
                res.moved = 1'b1;
                w = cdz_pkg::CAM_W'(c + stp);
                c = $signed(w);
                st.dir = cdz_pkg::DIR_W'(stp);
                st.rem = w[cdz_pkg::REM_W-1:0];
            end
        end
        st.cam = cdz_pkg::CAM_W'(c);
        res.st = st;
        return res;
    endfunction

    // keep sliding toward the next tile boundary by the last step
    function automatic cdz_pkg::t_axis_state glide_axis(cdz_pkg::t_axis_state st);
        int d;
        if (st.rem != '0) begin
            d = $signed(st.dir);
            st.rem = cdz_pkg::REM_W'(int'(st.rem) + d);
            st.cam = cdz_pkg::CAM_W'(int'($signed(st.cam)) + d);
        end
        return st;
    endfunction

    function automatic t_view_result predict_view(logic req,
                                                  logic [cdz_pkg::POS_W-1:0] px,
                                                  logic [cdz_pkg::POS_W-1:0] py,
                                                  logic [cdz_pkg::STEP_W-1:0] stp);
        t_view_result r;
        t_axis_move   mx;
        t_axis_move   my;
        r.scrolled = 1'b0;
        if (req == cdz_pkg::REQ_LOAD) begin
            track_x.cam = {1'b0, px};
            track_y.cam = {1'b0, py};
            track_x.rem = '0;
            track_y.rem = '0;
        end else begin
            mx = scroll_axis(track_x, int'(px), int'(stp), int'(view_cfg.margin_left),
                             int'(view_cfg.margin_right), int'(view_cfg.limit_x));
            my = scroll_axis(track_y, int'(py), int'(stp), int'(view_cfg.margin_top),
                             int'(view_cfg.margin_bottom), int'(view_cfg.limit_y));
            track_x = mx.st;
            track_y = my.st;
            r.scrolled = mx.moved | my.moved;
            if (!r.scrolled) begin
                track_x = glide_axis(track_x);
                track_y = glide_axis(track_y);
            end
        end
        r.view_x = track_x.cam;
        r.view_y = track_y.cam;
        return r;
    endfunction

    // cursor inside the dead zone on request, else near a zone edge, at a map edge, inside the zone or anywhere
    function automatic logic [cdz_pkg::POS_W-1:0] pick_cursor(int cam, int mlow,
                                                              int mhigh, bit inside_zone);
        int lo;
        int hi;
        int p;
        lo = cam + mlow;
        hi = cam + mhigh;
        if (lo > hi) begin
            p  = lo;
            lo = hi;
            hi = p;
        end
        if (inside_zone) begin
            p = lo + int'($urandom_range(hi - lo));
        end else begin
            case ($urandom_range(5))
                0: p = cam + mlow + int'($urandom_range(6)) - 3;
                1: p = cam + mhigh + int'($urandom_range(6)) - 3;
                2: p = ($urandom_range(1) == 1) ? 4095 : 0;
                3: p = lo + int'($urandom_range(hi - lo));
                default: p = int'($urandom_range(4095));
            endcase
        end
        if (p < 0) p = 0;
        else if (p > 4095) p = 4095;
        return cdz_pkg::POS_W'(p);
    endfunction

    function automatic t_probe_row cfg_row(logic [cdz_pkg::CFG_IDX_W-1:0] idx, int data);
        t_probe_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = cdz_pkg::CFG_DATA_W'(data);
        return row;
    endfunction

    function automatic t_probe_row item_row(logic req, int px, int py, int stp);
        t_probe_row row;
        row = '0;
        row.req = req;
        row.px = cdz_pkg::POS_W'(px);
        row.py = cdz_pkg::POS_W'(py);
        row.stp = cdz_pkg::STEP_W'(stp);
        return row;
    endfunction

    function automatic t_probe_row typed_row(logic req, int px, int py, int stp,
                                             int vx, int vy, logic sc);
        t_probe_row row;
        row = item_row(req, px, py, stp);
        row.typed = 1'b1;
        row.want.view_x = cdz_pkg::CAM_W'(vx);
        row.want.view_y = cdz_pkg::CAM_W'(vy);
        row.want.scrolled = sc;
        return row;
    endfunction

    task automatic send_item(input logic req, input logic [cdz_pkg::POS_W-1:0] px,
                             input logic [cdz_pkg::POS_W-1:0] py,
                             input logic [cdz_pkg::STEP_W-1:0] stp,
                             input logic typed, input t_view_result typed_view);
        t_view_result pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, stp, py, px};
        i_s_tuser  <= req;
        do @(posedge i_clk); while (!o_s_tready);
        pred = predict_view(req, px, py, stp);
        expected_views.push_back(typed ? typed_view : pred);
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain_views();
        i_s_tvalid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (expected_views.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    // valid is left high; the caller lowers it once the last write is done
    task automatic cfg_write(input logic [cdz_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cdz_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            cdz_pkg::CFG_LIMIT_X:
                view_cfg.limit_x = data[cdz_pkg::POS_W-1:0];
            cdz_pkg::CFG_LIMIT_Y:
                view_cfg.limit_y = data[cdz_pkg::POS_W-1:0];
            cdz_pkg::CFG_MARGIN_LEFT:
                view_cfg.margin_left = data[cdz_pkg::MARGIN_W-1:0];
            cdz_pkg::CFG_MARGIN_RIGHT:
                view_cfg.margin_right = data[cdz_pkg::MARGIN_W-1:0];
            cdz_pkg::CFG_MARGIN_TOP:
                view_cfg.margin_top = data[cdz_pkg::MARGIN_W-1:0];
            cdz_pkg::CFG_MARGIN_BOTTOM:
                view_cfg.margin_bottom = data[cdz_pkg::MARGIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_view_cfg(input int lx, input int ly, input int ml, input int mr,
                                input int mt, input int mb);
        drain_views();
        cfg_write(cdz_pkg::CFG_LIMIT_X, cdz_pkg::CFG_DATA_W'(lx));
        cfg_write(cdz_pkg::CFG_LIMIT_Y, cdz_pkg::CFG_DATA_W'(ly));
        cfg_write(cdz_pkg::CFG_MARGIN_LEFT, cdz_pkg::CFG_DATA_W'(ml));
        cfg_write(cdz_pkg::CFG_MARGIN_RIGHT, cdz_pkg::CFG_DATA_W'(mr));
        cfg_write(cdz_pkg::CFG_MARGIN_TOP, cdz_pkg::CFG_DATA_W'(mt));
        cfg_write(cdz_pkg::CFG_MARGIN_BOTTOM, cdz_pkg::CFG_DATA_W'(mb));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        logic                       req;
        logic [cdz_pkg::POS_W-1:0]  px;
        logic [cdz_pkg::POS_W-1:0]  py;
        logic [cdz_pkg::STEP_W-1:0] stp;
        bit                         both_inside;
        req = ($urandom_range(9) == 0) ? cdz_pkg::REQ_LOAD : cdz_pkg::REQ_TICK;
        stp = ($urandom_range(4) == 0) ? cdz_pkg::STEP_W'($urandom_range(31))
                                       : cdz_pkg::STEP_W'($urandom_range(16));
        if (req == cdz_pkg::REQ_LOAD) begin
            px = cdz_pkg::POS_W'($urandom_range(4095));
            py = cdz_pkg::POS_W'($urandom_range(4095));
        end else begin
            // both cursors inside the zone now and then, so glides get exercised
            both_inside = ($urandom_range(3) == 0);
            px = pick_cursor($signed(track_x.cam), int'(view_cfg.margin_left),
                             int'(view_cfg.margin_right), both_inside);
            py = pick_cursor($signed(track_y.cam), int'(view_cfg.margin_top),
                             int'(view_cfg.margin_bottom), both_inside);
        end
        send_item(req, px, py, stp, 1'b0, '0);
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s at %0t: expected %0d, got %0d", what, $realtime,
                     want, got);
    endtask

    // result side: random stalls and comparison with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_view_result want;
        if (o_m_tvalid && i_m_tready) begin
            if (expected_views.size() == 0) begin
                note_mismatch("unexpected transaction", 0, int'(o_m_tdata));
            end else begin
                want = expected_views.pop_front();
                if (o_m_tdata[12:0] !== want.view_x)
                    note_mismatch("view_x", $signed(want.view_x), $signed(o_m_tdata[12:0]));
                if (o_m_tdata[25:13] !== want.view_y)
                    note_mismatch("view_y", $signed(want.view_y), $signed(o_m_tdata[25:13]));
                if (o_m_tdata[26] !== want.scrolled)
                    note_mismatch("scrolled", int'(want.scrolled), int'(o_m_tdata[26]));
            end
        end
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int ml;
        int mt;
        track_x = '0;
        track_y = '0;
        view_cfg.limit_x       = '0;
        view_cfg.limit_y       = '0;
        view_cfg.margin_left   = cdz_pkg::MARGIN_LEFT_RST;
        view_cfg.margin_right  = cdz_pkg::MARGIN_RIGHT_RST;
        view_cfg.margin_top    = cdz_pkg::MARGIN_TOP_RST;
        view_cfg.margin_bottom = cdz_pkg::MARGIN_BOTTOM_RST;

        // reset registers: loads, then snaps on both sides with zero limits
        probe_rows.push_back(typed_row(cdz_pkg::REQ_LOAD, 100, 200, 5, 100, 200, 1'b0));
        probe_rows.push_back(typed_row(cdz_pkg::REQ_LOAD, 4095, 4095, 31, 4095, 4095, 1'b0));
        probe_rows.push_back(typed_row(cdz_pkg::REQ_LOAD, 0, 0, 0, 0, 0, 1'b0));
        probe_rows.push_back(typed_row(cdz_pkg::REQ_TICK, 100, 50, 4, 0, 0, 1'b0));
        probe_rows.push_back(typed_row(cdz_pkg::REQ_TICK, 0, 0, 16, 0, 0, 1'b0));
        probe_rows.push_back(typed_row(cdz_pkg::REQ_TICK, 4095, 4095, 16, 0, 0, 1'b0));
        probe_rows.push_back(cfg_row(cdz_pkg::CFG_LIMIT_X, 4095));
        probe_rows.push_back(cfg_row(cdz_pkg::CFG_LIMIT_Y, 4095));
        // scroll right/down, then glide with an odd remainder
        probe_rows.push_back(item_row(cdz_pkg::REQ_TICK, 4095, 4095, 16));
        probe_rows.push_back(item_row(cdz_pkg::REQ_TICK, 4095, 4095, 7));
        probe_rows.push_back(item_row(cdz_pkg::REQ_TICK, 150, 100, 3));
        probe_rows.push_back(item_row(cdz_pkg::REQ_TICK, 150, 100, 3));
        probe_rows.push_back(item_row(cdz_pkg::REQ_TICK, 150, 100, 3));
        // large steps
        probe_rows.push_back(item_row(cdz_pkg::REQ_TICK, 4095, 0, 31));
        probe_rows.push_back(item_row(cdz_pkg::REQ_TICK, 0, 4095, 17));
        // camera wraps below zero, then glides further negative
        probe_rows.push_back(item_row(cdz_pkg::REQ_LOAD, 20, 20, 9));
        probe_rows.push_back(item_row(cdz_pkg::REQ_TICK, 60, 40, 31));
        probe_rows.push_back(item_row(cdz_pkg::REQ_TICK, 100, 60, 0));
        // left above right: both sides act in one tick
        probe_rows.push_back(cfg_row(cdz_pkg::CFG_MARGIN_LEFT, 255));
        probe_rows.push_back(cfg_row(cdz_pkg::CFG_MARGIN_RIGHT, 0));
        probe_rows.push_back(cfg_row(cdz_pkg::CFG_MARGIN_TOP, 255));
        probe_rows.push_back(cfg_row(cdz_pkg::CFG_MARGIN_BOTTOM, 0));
        probe_rows.push_back(item_row(cdz_pkg::REQ_LOAD, 1000, 1000, 0));
        probe_rows.push_back(item_row(cdz_pkg::REQ_TICK, 1100, 1100, 5));
        probe_rows.push_back(item_row(cdz_pkg::REQ_TICK, 4095, 4095, 16));
        probe_rows.push_back(item_row(cdz_pkg::REQ_TICK, 0, 0, 1));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probe_rows[n]) begin
            if (probe_rows[n].is_cfg) begin
                drain_views();
                cfg_write(probe_rows[n].idx, probe_rows[n].data);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) begin
                    i_cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_item(probe_rows[n].req, probe_rows[n].px, probe_rows[n].py,
                          probe_rows[n].stp, probe_rows[n].typed, probe_rows[n].want);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_view_cfg(4095, 4095, cdz_pkg::MARGIN_LEFT_RST,
                                cdz_pkg::MARGIN_RIGHT_RST, cdz_pkg::MARGIN_TOP_RST,
                                cdz_pkg::MARGIN_BOTTOM_RST);
                1: begin
                    ml = $urandom_range(120);
                    mt = $urandom_range(120);
                    set_view_cfg($urandom_range(200, 4095), $urandom_range(200, 4095),
                                 ml, ml + $urandom_range(135), mt, mt + $urandom_range(135));
                end
                2: set_view_cfg(0, 4095, 0, 255, 255, 0);
                default: set_view_cfg($urandom_range(4095), $urandom_range(4095),
                                      $urandom_range(255), $urandom_range(255),
                                      $urandom_range(255), $urandom_range(255));
            endcase
            send_idle_pct  = (ph == 1) ? 62 : (ph == 3) ? 33 : 0;
            recv_stall_pct = (ph == 2) ? 62 : (ph == 3) ? 33 : 0;
            for (int k = 0; k < RANDOM_ITEMS / 4; k++)
                random_item();
        end

        drain_views();
        if (mismatch_count == 0 && expected_views.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// File: files.f
sv/cdz_pkg.sv
sv/cdz_cfg.sv
sv/cdz_axis.sv
sv/camera_deadzone_scroll_core.sv
sv/cdz_checker.sv
tb/tb.sv
